// File: sv/moddiv_pkg.sv
// ----------------------------------------------------------------------------
// Modular divider package
// Widths, reset value and sequencer codes for the modular divider.
// ----------------------------------------------------------------------------
package moddiv_pkg;

  localparam int VALUE_WIDTH   = 31;
  localparam int CNT_WIDTH     = $clog2(VALUE_WIDTH);
  localparam int IN_TDATA_W    = ((2 * VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W   = ((VALUE_WIDTH + 7) / 8) * 8;

  localparam logic [VALUE_WIDTH-1:0] MODULUS_RESET = VALUE_WIDTH'(998244353);

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ALIGN = 7'b0000010,
    ST_SUB   = 7'b0000100,
    ST_CHECK = 7'b0001000,
    ST_FIX   = 7'b0010000,
    ST_MUL   = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  // what the current long division is for
  typedef enum logic [1:0] {
    JOB_DVD = 2'd0,  // reduce dividend modulo modulus
    JOB_DVS = 2'd1,  // reduce divisor modulo modulus
    JOB_EUC = 2'd2   // one extended Euclid step
  } job_t;

endpackage

// File: sv/modular_divide_ext_euclid_top.sv
// ----------------------------------------------------------------------------
// Modular divider (extended Euclid)
// Returns dividend times the inverse of divisor, modulo a programmable modulus.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per transfer: dividend and divisor. m_axis returns
//   one result per item: the quotient in tdata, the no-inverse flag in tuser.
//   cfg_* writes the modulus (always ready); write it only while idle.
//   A modulus of zero, a divisor that reduces to zero, or one that shares a
//   factor with the modulus gives no_inverse = 1 and a quotient of zero.
// Datapath and flow:
//   One item at a time through a shared shift/subtract datapath. Both operands
//   are first reduced modulo the modulus by long division. Each Euclid step is
//   a long division followed by a check of the new remainder; the inverse is
//   then multiplied into the reduced dividend by shift-and-add, one bit of
//   the inverse at a time. s_axis_tready is high only between items.
// Reset and stall:
//   rst (synchronous) clears the sequencer and output valid, and loads the
//   modulus with 998244353. A finished result waits in the output register;
//   a new item may be accepted meanwhile, and its result waits in the final
//   state until the output register is free.
// ----------------------------------------------------------------------------
module modular_divide_ext_euclid_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [moddiv_pkg::VALUE_WIDTH-1:0]    cfg_data,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [moddiv_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // dividend, divisor, pad
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [moddiv_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // quotient, pad
  output logic [0:0]                            m_axis_tuser    // no_inverse
);

  localparam int W  = moddiv_pkg::VALUE_WIDTH;
  localparam int CW = moddiv_pkg::CNT_WIDTH;

  moddiv_pkg::state_t state;
  moddiv_pkg::job_t   job;

  logic [W-1:0]          modulus;
  logic [W-1:0]          r0, r1, num, xval, acc, mx, my;
  logic [W:0]            s;
  logic signed [W+1:0]   t0, t1, ts;
  logic [CW-1:0]         cnt;
  logic                  no_inv;

  logic [W+1:0]          s_dbl;
  logic                  align_go;
  logic                  sub_ge;
  logic [W-1:0]          num_after;
  logic signed [W+1:0]   t0_after;
  logic signed [W+1:0]   inv_fix;
  logic [W:0]            sum_acc, sum_dbl;
  logic [W-1:0]          acc_add, mx_dbl;
  logic [W-1:0]          in_dividend, in_divisor;

  assign in_dividend   = s_axis_tdata[W-1:0];
  assign in_divisor    = s_axis_tdata[2*W-1:W];
  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == moddiv_pkg::ST_IDLE);

  // shared shift/subtract unit of the long division
  assign s_dbl     = {s, 1'b0};
  assign align_go  = (s_dbl <= {2'b00, num});
  assign sub_ge    = ({1'b0, num} >= s);
  assign num_after = sub_ge ? (num - s[W-1:0]) : num;
  assign t0_after  = sub_ge ? (t0 - ts) : t0;

  // bring the Bezout coefficient into range
  assign inv_fix = t1[W+1] ? (t1 + $signed({2'b00, modulus})) : t1;

  // modular add and double for the shift-and-add multiply
  always_comb begin
    sum_acc = {1'b0, acc} + {1'b0, mx};
    sum_dbl = {mx, 1'b0};
    acc_add = (sum_acc >= {1'b0, modulus}) ? W'(sum_acc - {1'b0, modulus}) : sum_acc[W-1:0];
    mx_dbl  = (sum_dbl >= {1'b0, modulus}) ? W'(sum_dbl - {1'b0, modulus}) : sum_dbl[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= moddiv_pkg::MODULUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      modulus <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= moddiv_pkg::ST_IDLE;
      job           <= moddiv_pkg::JOB_DVD;
      m_axis_tvalid <= 1'b0;
    end else begin
      // drop valid after the transfer; the final state reloads it itself
      if (m_axis_tvalid && m_axis_tready && state != moddiv_pkg::ST_FIN) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        moddiv_pkg::ST_IDLE: begin
          if (s_axis_tvalid) begin
            if (modulus == '0) begin
              no_inv <= 1'b1;
              acc    <= '0;
              state  <= moddiv_pkg::ST_FIN;
            end else begin
              num   <= in_dividend;
              r1    <= in_divisor;
              s     <= {1'b0, modulus};
              ts    <= '0;
              cnt   <= '0;
              job   <= moddiv_pkg::JOB_DVD;
              state <= moddiv_pkg::ST_ALIGN;
            end
          end
        end
        moddiv_pkg::ST_ALIGN: begin
          // shift the divisor up until one more shift would pass the remainder
          if (align_go) begin
            s   <= s_dbl[W:0];
            ts  <= ts <<< 1;
            cnt <= cnt + CW'(1);
          end else begin
            state <= moddiv_pkg::ST_SUB;
          end
        end
        moddiv_pkg::ST_SUB: begin
          if (cnt == '0) begin
            case (job)
              moddiv_pkg::JOB_DVD: begin
                xval  <= num_after;
                num   <= r1;
                s     <= {1'b0, modulus};
                ts    <= '0;
                job   <= moddiv_pkg::JOB_DVS;
                state <= moddiv_pkg::ST_ALIGN;
              end
              moddiv_pkg::JOB_DVS: begin
                r0    <= modulus;
                r1    <= num_after;
                t0    <= '0;
                t1    <= {{(W+1){1'b0}}, 1'b1};
                state <= moddiv_pkg::ST_CHECK;
              end
              default: begin
                r0    <= r1;
                r1    <= num_after;
                t0    <= t1;
                t1    <= t0_after;
                state <= moddiv_pkg::ST_CHECK;
              end
            endcase
          end else begin
            num <= num_after;
            t0  <= t0_after;
            s   <= s >> 1;
            ts  <= ts >>> 1;
            cnt <= cnt - CW'(1);
          end
        end
        moddiv_pkg::ST_CHECK: begin
          if (r1 == W'(1)) begin
            state <= moddiv_pkg::ST_FIX;
          end else if (r1 == '0) begin
            // gcd is not one: no inverse
            no_inv <= 1'b1;
            acc    <= '0;
            state  <= moddiv_pkg::ST_FIN;
          end else begin
            num   <= r0;
            s     <= {1'b0, r1};
            ts    <= t1;
            cnt   <= '0;
            job   <= moddiv_pkg::JOB_EUC;
            state <= moddiv_pkg::ST_ALIGN;
          end
        end
        moddiv_pkg::ST_FIX: begin
          my     <= inv_fix[W-1:0];
          mx     <= xval;
          acc    <= '0;
          no_inv <= 1'b0;
          state  <= moddiv_pkg::ST_MUL;
        end
        moddiv_pkg::ST_MUL: begin
          if (my == '0) begin
            state <= moddiv_pkg::ST_FIN;
          end else begin
            if (my[0]) begin
              acc <= acc_add;
            end
            mx <= mx_dbl;
            my <= my >> 1;
          end
        end
        moddiv_pkg::ST_FIN: begin
          // hold until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {{(moddiv_pkg::OUT_TDATA_W-W){1'b0}}, acc};
            m_axis_tuser  <= no_inv;
            state         <= moddiv_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= moddiv_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular divider testbench
// Drives dividend/divisor pairs over several modulus settings and checks each
// quotient and no-inverse flag against a directed table's typed values or an
// extended Euclid predictor. The table covers the extremes and the no-inverse
// cases. Random phases follow; all but two put random gaps on both stream sides.
// ----------------------------------------------------------------------------
module testbench;

  localparam int VALUE_WIDTH = moddiv_pkg::VALUE_WIDTH;
  localparam int IN_TDATA_W  = moddiv_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = moddiv_pkg::OUT_TDATA_W;
  localparam logic [VALUE_WIDTH-1:0] MODULUS_RESET = moddiv_pkg::MODULUS_RESET;

  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 400;
  localparam int RANDOM_PHASES = 12;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] quotient;
    logic                   no_inverse;
  } division_t;

  typedef struct packed {
    logic                   set_mod;
    logic [VALUE_WIDTH-1:0] modulus;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [VALUE_WIDTH-1:0] divisor;
    logic                   typed;
    logic [VALUE_WIDTH-1:0] want_quotient;
    logic                   want_no_inverse;
  } step_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [VALUE_WIDTH-1:0] cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // dividend, divisor, pad
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // quotient, pad
  logic [0:0]             m_axis_tuser;        // no_inverse

  division_t              quot_expect [$];
  logic [VALUE_WIDTH-1:0] modulus_setting = MODULUS_RESET;
  logic                   no_stall = 1'b0;
  int                     items_sent = 0;
  int                     results_seen = 0;
  int                     errors = 0;

  // set_mod, modulus, dividend, divisor, typed, quotient, no_inverse
  step_row_t directed_rows [25] = '{
    '{0, 0,          0,          0,          1, 0,          1},  // zero divisor
    '{0, 0,          5,          1,          1, 5,          0},
    '{0, 0,          1,          998244353,  1, 0,          1},  // divisor equals modulus
    '{0, 0,          7,          998244354,  1, 7,          0},
    '{0, 0,          998244352,  998244352,  1, 1,          0},
    '{0, 0,          2147483647, 1,          1, 150994941,  0},  // dividend above modulus
    '{0, 0,          0,          2147483647, 1, 0,          0},
    '{0, 0,          1,          2,          1, 499122177,  0},
    '{0, 0,          1,          998244352,  1, 998244352,  0},
    '{0, 0,          2147483647, 2147483647, 1, 1,          0},
    '{0, 0,          1431655765, 715827882,  0, 0,          0},
    '{0, 0,          123456789,  3,          0, 0,          0},
    '{1, 0,          3,          5,          1, 0,          1},  // modulus zero
    '{1, 1,          0,          1,          1, 0,          1},  // modulus one
    '{0, 0,          2147483647, 2147483647, 1, 0,          1},
    '{1, 2,          1,          1,          1, 1,          0},  // modulus two
    '{0, 0,          1,          2,          1, 0,          1},
    '{0, 0,          2147483647, 2147483647, 1, 1,          0},
    '{1, 2147483647, 2147483646, 2147483646, 1, 1,          0},
    '{0, 0,          5,          2147483647, 1, 0,          1},
    '{0, 0,          2147483647, 1,          1, 0,          0},
    '{1, 12,         5,          4,          1, 0,          1},  // shared factor
    '{1, 12,         5,          5,          1, 1,          0},
    '{0, 0,          11,         7,          0, 0,          0},
    '{1, 998244353,  3,          3,          1, 1,          0}
  };

  modular_divide_ext_euclid_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Extended Euclid with the Bezout coefficient kept modulo m.
  function automatic division_t divide_mod(input logic [VALUE_WIDTH-1:0] dvd,
                                           input logic [VALUE_WIDTH-1:0] dvs,
                                           input logic [VALUE_WIDTH-1:0] m);
    longint unsigned mm, r0, r1, t0, t1, t2, q, rem;
    division_t       res;
    res.quotient   = '0;
    res.no_inverse = 1'b1;
    if (m == 0) return res;
    mm = m;
    r0 = mm;
    r1 = longint'(dvs) % mm;
    t0 = 0;
    t1 = 1 % mm;
    while (r1 != 1) begin
      if (r1 == 0) return res;
      q   = r0 / r1;
      rem = r0 % r1;
      t2  = (t0 + mm - (q * t1) % mm) % mm;
      r0  = r1;
      r1  = rem;
      t0  = t1;
      t1  = t2;
    end
    res.quotient   = VALUE_WIDTH'(((longint'(dvd) % mm) * t1) % mm);
    res.no_inverse = 1'b0;
    return res;
  endfunction

  task automatic send_item(input logic [VALUE_WIDTH-1:0] dvd,
                           input logic [VALUE_WIDTH-1:0] dvs,
                           input logic typed, input division_t typed_want);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 6);
    // valid stays high from the previous transfer unless a gap is due
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= IN_TDATA_W'({dvs, dvd});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    quot_expect.push_back(typed ? typed_want : divide_mod(dvd, dvs, modulus_setting));
  endtask

  // Hold the input side until every outstanding result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [VALUE_WIDTH-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    modulus_setting = value;
  endtask

  initial begin : stimulus
    step_row_t              row;
    division_t              typed_want;
    logic [VALUE_WIDTH-1:0] dvd, dvs, m;
    int                     n_items;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.set_mod) begin
        drain_results();
        write_modulus(row.modulus);
      end
      typed_want.quotient   = row.want_quotient;
      typed_want.no_inverse = row.want_no_inverse;
      send_item(row.dividend, row.divisor, row.typed, typed_want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0, 10:     m = MODULUS_RESET;
        1:         m = '1;
        3:         m = VALUE_WIDTH'($urandom_range(3, 100));
        5:         m = VALUE_WIDTH'(1000000007);
        6:         m = VALUE_WIDTH'($urandom_range(3, 1000));
        7:         m = VALUE_WIDTH'($urandom_range(0, 2));
        8:         m = VALUE_WIDTH'($urandom);
        9:         m = VALUE_WIDTH'(2147483646);
        default:   m = VALUE_WIDTH'($urandom_range(3, 2147483647));
      endcase
      drain_results();
      write_modulus(m);
      no_stall = (p == 3 || p == 8);
      n_items  = (p == 7) ? 20 : 44;
      for (int k = 0; k < n_items; k++) begin
        case ($urandom_range(0, 9))
          0:       dvs = '0;
          1:       dvs = VALUE_WIDTH'(modulus_setting * $urandom_range(1, 3));
          2:       dvs = VALUE_WIDTH'($urandom_range(1, 16));
          3:       dvs = modulus_setting - 1'b1;
          default: dvs = VALUE_WIDTH'($urandom);
        endcase
        case ($urandom_range(0, 7))
          0:       dvd = '0;
          1:       dvd = '1;
          2:       dvd = modulus_setting - 1'b1;
          default: dvd = VALUE_WIDTH'($urandom);
        endcase
        send_item(dvd, dvs, 1'b0, '0);
        if ($urandom_range(0, 39) == 0) drain_results();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (quot_expect.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, quot_expect.size());
      errors += quot_expect.size();
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : result_sink
    int gap;
    forever begin
      gap = no_stall ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk) begin : check_results
    division_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (quot_expect.size() == 0) begin
        $display("%0t: unexpected result, expected none, got quotient %0d no_inverse %0d",
                 $time, m_axis_tdata[VALUE_WIDTH-1:0], m_axis_tuser[0]);
        errors++;
      end else begin
        want = quot_expect.pop_front();
        if (m_axis_tdata[VALUE_WIDTH-1:0] !== want.quotient) begin
          $display("%0t: quotient expected %0d, got %0d",
                   $time, want.quotient, m_axis_tdata[VALUE_WIDTH-1:0]);
          errors++;
        end
        if (m_axis_tuser[0] !== want.no_inverse) begin
          $display("%0t: no_inverse expected %0d, got %0d",
                   $time, want.no_inverse, m_axis_tuser[0]);
          errors++;
        end
      end
    end
  end

  // Give up once no transfer of any kind has happened for too long.
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: files.f
sv/moddiv_pkg.sv
sv/modular_divide_ext_euclid_top.sv
test/testbench.sv
